// ===== design/two_threshold_spike_select_defines.svh =====
// assertion macros used by the spike select design
`ifndef TWO_THRESHOLD_SPIKE_SELECT_DEFINES_SVH
`define TWO_THRESHOLD_SPIKE_SELECT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spike select check failed");

// next-cycle implication, sampled on clk, off during reset
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spike select check failed");

`endif

// ===== design/tts_pkg.sv =====
// types and constants of the two-threshold spike select block
`default_nettype none
package tts_pkg;

  localparam int VAL_W    = 16;
  localparam int NCOUNT_W = 13;
  localparam int LLEN_W   = 9;
  localparam int ID_W     = 20;
  localparam int RATIO_W  = 16;
  localparam int SLOT_W   = 8;
  localparam int TOTAL_W  = 9;
  localparam int PROD_W   = VAL_W + RATIO_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEURON_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NEURON_ID = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE_RATIO = 2'd3;

  // register reset values
  localparam logic [NCOUNT_W-1:0] NEURON_COUNT_RESET = 13'd4096;
  localparam logic [LLEN_W-1:0]   LIST_LENGTH_RESET  = 9'd256;
  localparam logic [ID_W-1:0]     FIRST_ID_RESET     = 20'd0;
  localparam logic [RATIO_W-1:0]  RATIO_RESET        = 16'd58982;

  typedef struct packed {
    logic signed [VAL_W-1:0] membrane_value;
    logic signed [VAL_W-1:0] fire_level;
  } in_word_t;

  typedef struct packed {
    logic               slot_write;
    logic [SLOT_W-1:0]  slot_index;
    logic [ID_W-1:0]    neuron_id;
    logic               is_spike;
    logic               pass_done;
    logic [TOTAL_W-1:0] spike_total;
  } out_word_t;

  typedef struct packed {
    logic [NCOUNT_W-1:0] neuron_count;
    logic [LLEN_W-1:0]   list_length;
    logic [ID_W-1:0]     first_neuron_id;
    logic [RATIO_W-1:0]  candidate_ratio;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/tts_stage.sv =====
// one valid/stall register stage holding a word
`default_nettype none
module tts_stage #(
  parameter type word_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  output logic  stall_o,
  input  word_t data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output word_t data_o
);

  logic  valid_r;
  word_t data_r;

  // hold only while a word sits here and the next side refuses it
  assign stall_o = valid_r && stall_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o) begin
      data_r <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/tts_select.sv =====
// pass state and per-neuron keep, spike and slot decision
`default_nettype none
`include "two_threshold_spike_select_defines.svh"
module tts_select #(
  parameter int MAX_LIST    = 256,
  parameter int MAX_NEURONS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tts_pkg::cfg_t      cfg,
  input  logic               fire,
  input  tts_pkg::in_word_t  item,
  output tts_pkg::out_word_t result
);
  import tts_pkg::*;

  localparam int POS_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int NW    = $clog2(MAX_NEURONS + 1);
  localparam int NCW   = (NW > NCOUNT_W) ? NW : NCOUNT_W;
  localparam int CNT_W = $clog2(MAX_LIST + 1);
  localparam int LCW   = (CNT_W > LLEN_W) ? CNT_W : LLEN_W;
  localparam int CW    = (NW > CNT_W) ? NW : CNT_W;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] back_r, back_nxt;
  logic             full_r, full_nxt;

  logic [NCW-1:0]   n_wide;
  logic [NW-1:0]    n_cl;
  logic [LCW-1:0]   len_wide;
  logic [CNT_W-1:0] len_cl;
  logic [NW-1:0]    pos_w;
  logic [NW-1:0]    remaining;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] open_slots;
  logic [CNT_W-1:0] slot;
  logic [CNT_W:0]   used_ext;
  logic             last;
  logic             cand;
  logic             keep;
  logic             spike;
  logic             write;
  logic             done;

  logic signed [PROD_W-1:0] lhs;
  logic signed [PROD_W-1:0] prod;

  // value in Q17.16 against threshold times ratio in Q17.16
  assign lhs  = {item.membrane_value[VAL_W-1], item.membrane_value, {RATIO_W{1'b0}}};
  assign prod = item.fire_level * $signed({1'b0, cfg.candidate_ratio});
  assign cand = lhs > prod;

  always_comb begin
    n_wide = NCW'(cfg.neuron_count);
    if (n_wide == '0) begin
      n_cl = NW'(1);
    end else if (n_wide > NCW'(MAX_NEURONS)) begin
      n_cl = NW'(MAX_NEURONS);
    end else begin
      n_cl = NW'(n_wide);
    end

    len_wide = LCW'(cfg.list_length);
    if (len_wide == '0) begin
      len_cl = CNT_W'(1);
    end else if (len_wide > LCW'(MAX_LIST)) begin
      len_cl = CNT_W'(MAX_LIST);
    end else begin
      len_cl = CNT_W'(len_wide);
    end

    pos_w      = NW'(pos_r);
    last       = (pos_w + NW'(1)) >= n_cl;
    remaining  = (pos_w < n_cl) ? n_cl - pos_w : NW'(1);
    used       = front_r + back_r;
    open_slots = len_cl - used;
    keep       = cand || (CW'(remaining) <= CW'(open_slots));
    spike      = 1'b0;
    write      = 1'b0;
    done       = 1'b0;
    slot       = '0;
    front_nxt  = front_r;
    back_nxt   = back_r;
    full_nxt   = full_r;

    if (!full_r) begin
      if (used >= len_cl) begin
        // list shortened under a running pass
        full_nxt = 1'b1;
        done     = 1'b1;
      end else begin
        if (keep) begin
          write = 1'b1;
          if (item.membrane_value > item.fire_level) begin
            spike     = 1'b1;
            slot      = front_r;
            front_nxt = front_r + CNT_W'(1);
          end else begin
            slot     = len_cl - CNT_W'(1) - back_r;
            back_nxt = back_r + CNT_W'(1);
          end
          if (used + CNT_W'(1) >= len_cl) begin
            full_nxt = 1'b1;
            done     = 1'b1;
          end
        end
        if (last) begin
          done = 1'b1;
        end
      end
    end

    result.slot_write  = write;
    result.slot_index  = write ? SLOT_W'(slot) : '0;
    result.neuron_id   = cfg.first_neuron_id + ID_W'(pos_r);
    result.is_spike    = spike;
    result.pass_done   = done;
    result.spike_total = TOTAL_W'(front_nxt);

    pos_nxt = last ? '0 : pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      front_r <= '0;
      back_r  <= '0;
      full_r  <= 1'b0;
    end else if (fire) begin
      if (last) begin
        pos_r   <= '0;
        front_r <= '0;
        back_r  <= '0;
        full_r  <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        front_r <= front_nxt;
        back_r  <= back_nxt;
        full_r  <= full_nxt;
      end
    end
  end

  assign used_ext = (CNT_W + 1)'(front_r) + (CNT_W + 1)'(back_r);

  `TTS_ASSERT_NOW(a_used_bound, 1'b1, used_ext <= (CNT_W + 1)'(MAX_LIST))
  `TTS_ASSERT_NOW(a_no_write_when_full, full_r, !result.slot_write && !result.pass_done)
  `TTS_ASSERT_NEXT(a_pass_end_clears, fire && last,
                   pos_r == '0 && front_r == '0 && back_r == '0 && !full_r)
  `TTS_ASSERT_NEXT(a_early_done_marks_full, fire && result.pass_done && !last, full_r)

endmodule
`default_nettype wire

// ===== design/two_threshold_spike_select.sv =====
`default_nettype none
// Two-threshold spike select: takes one neuron word per cycle (membrane value
// and threshold) while not stalled and returns one result word per neuron via
// the input register, the select logic and the output register. The rate is
// set by the combinational select path between the input and output
// registers, where one 16x17 signed multiply and the slot counters of the
// running pass are updated together. A stalled output does not block the
// input side until both registers hold words. Configuration is written
// through cfg_wr_en/cfg_index/cfg_data and must only change while the block is idle.
module two_threshold_spike_select #(
  parameter int MAX_LIST    = 256,
  parameter int MAX_NEURONS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tts_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tts_pkg::out_word_t                   out_data,
  input  logic                                 cfg_wr_en,
  input  logic [tts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tts_pkg::*;

  cfg_t      cfg_r;
  in_word_t  held_word;
  out_word_t sel_word;
  logic      held_valid;
  logic      out_side_stall;
  logic      fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neuron_count    <= NEURON_COUNT_RESET;
      cfg_r.list_length     <= LIST_LENGTH_RESET;
      cfg_r.first_neuron_id <= FIRST_ID_RESET;
      cfg_r.candidate_ratio <= RATIO_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NEURON_COUNT:    cfg_r.neuron_count    <= cfg_data[NCOUNT_W-1:0];
        CFG_LIST_LENGTH:     cfg_r.list_length     <= cfg_data[LLEN_W-1:0];
        CFG_FIRST_NEURON_ID: cfg_r.first_neuron_id <= cfg_data[ID_W-1:0];
        CFG_CANDIDATE_RATIO: cfg_r.candidate_ratio <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  tts_stage #(.word_t(in_word_t)) u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .stall_o (in_stall),
    .data_i  (in_data),
    .valid_o (held_valid),
    .stall_i (out_side_stall),
    .data_o  (held_word)
  );

  // a word leaves the input register and updates the pass state together
  assign fire = held_valid && !out_side_stall;

  tts_select #(
    .MAX_LIST    (MAX_LIST),
    .MAX_NEURONS (MAX_NEURONS)
  ) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .fire   (fire),
    .item   (held_word),
    .result (sel_word)
  );

  tts_stage #(.word_t(out_word_t)) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (held_valid),
    .stall_o (out_side_stall),
    .data_i  (sel_word),
    .valid_o (out_valid),
    .stall_i (out_stall),
    .data_o  (out_data)
  );

endmodule
`default_nettype wire
